// ===== rtl/csph_pkg.sv =====
package csph_pkg;

  localparam int unsigned CoordBits = 12;

  typedef struct packed {
    logic signed [CoordBits-1:0] a_x;
    logic signed [CoordBits-1:0] a_y;
    logic signed [CoordBits-1:0] a_z;
    logic signed [CoordBits-1:0] b_x;
    logic signed [CoordBits-1:0] b_y;
    logic signed [CoordBits-1:0] b_z;
    logic signed [CoordBits-1:0] c_x;
    logic signed [CoordBits-1:0] c_y;
    logic signed [CoordBits-1:0] c_z;
    logic signed [CoordBits-1:0] p_x;
    logic signed [CoordBits-1:0] p_y;
    logic signed [CoordBits-1:0] p_z;
  } csph_in_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } csph_out_t;

endpackage

// ===== rtl/csph_geom.sv =====
// Front half: differences, normal, squared lengths, bisector combination.
module csph_geom (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  csph_pkg::csph_in_t                      item_i,
  output logic                                    valid_o,
  output logic signed [csph_pkg::CoordBits+1:0]   q_o [3],
  output logic signed [2*csph_pkg::CoordBits+3:0] n_o [3],
  output logic signed [4*csph_pkg::CoordBits+7:0] s_o [3]
);
  localparam int unsigned CoordBits = csph_pkg::CoordBits;
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned NW = 2 * CoordBits + 4;
  localparam int unsigned LW = 2 * CoordBits + 4;
  localparam int unsigned SW = 4 * CoordBits + 8;

  logic [2:0] vld_q;
  logic signed [DW-1:0] u_q [3], v_q [3], qd_q [3];
  logic signed [DW-1:0] u2_q [3], v2_q [3], q2_q [3];
  logic signed [NW-1:0] n2_q [3], n3_q [3];
  logic [LW-1:0] uu_q, vv_q;
  logic signed [DW:0] q3_q [3];
  logic signed [SW-1:0] s_q [3];
  logic signed [CoordBits-1:0] ca [3], cb [3], cc [3], cp [3];

  assign ca = '{item_i.a_x, item_i.a_y, item_i.a_z};
  assign cb = '{item_i.b_x, item_i.b_y, item_i.b_z};
  assign cc = '{item_i.c_x, item_i.c_y, item_i.c_z};
  assign cp = '{item_i.p_x, item_i.p_y, item_i.p_z};

  // Advance valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Stage 1: edge vectors relative to A.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      u_q[k]  <= DW'(cb[k]) - DW'(ca[k]);
      v_q[k]  <= DW'(cc[k]) - DW'(ca[k]);
      qd_q[k] <= DW'(cp[k]) - DW'(ca[k]);
    end
  end

  // Stage 2: normal and squared edge lengths.
  always_ff @(posedge clk_i) begin
    n2_q[0] <= NW'(u_q[1] * v_q[2]) - NW'(u_q[2] * v_q[1]);
    n2_q[1] <= NW'(u_q[2] * v_q[0]) - NW'(u_q[0] * v_q[2]);
    n2_q[2] <= NW'(u_q[0] * v_q[1]) - NW'(u_q[1] * v_q[0]);
    uu_q <= LW'(u_q[0] * u_q[0]) + LW'(u_q[1] * u_q[1]) + LW'(u_q[2] * u_q[2]);
    vv_q <= LW'(v_q[0] * v_q[0]) + LW'(v_q[1] * v_q[1]) + LW'(v_q[2] * v_q[2]);
    u2_q <= u_q;
    v2_q <= v_q;
    q2_q <= qd_q;
  end

  // Stage 3: s = |u|^2 v - |v|^2 u.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s_q[k] <= SW'($signed({1'b0, uu_q}) * v2_q[k])
              - SW'($signed({1'b0, vv_q}) * u2_q[k]);
      q3_q[k] <= (DW+1)'(q2_q[k]);
    end
    n3_q <= n2_q;
  end

  assign valid_o = vld_q[2];
  assign q_o = q3_q;
  assign n_o = n3_q;
  assign s_o = s_q;
endmodule

// ===== rtl/csph_test.sv =====
// Back half: w = s x n, |n|^2 |q|^2 against q . w.
module csph_test (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic signed [csph_pkg::CoordBits+1:0]   q_i [3],
  input  logic signed [2*csph_pkg::CoordBits+3:0] n_i [3],
  input  logic signed [4*csph_pkg::CoordBits+7:0] s_i [3],
  output logic                                    valid_o,
  output csph_pkg::csph_out_t                     res_o
);
  localparam int unsigned CoordBits = csph_pkg::CoordBits;
  localparam int unsigned QW  = CoordBits + 2;
  localparam int unsigned NW  = 2 * CoordBits + 4;
  localparam int unsigned SW  = 4 * CoordBits + 8;
  localparam int unsigned SH  = SW / 2;
  localparam int unsigned HPW = SW - SH + NW;
  localparam int unsigned LPW = SH + 1 + NW;
  localparam int unsigned WW  = SW + NW + 1;
  localparam int unsigned WC  = SH;
  localparam int unsigned NNW = 2 * NW;
  localparam int unsigned NNH = NNW / 2;
  localparam int unsigned QQW = 2 * QW;
  localparam int unsigned LPP = NNH + QQW;
  localparam int unsigned LHW = NNW + QQW;
  localparam int unsigned RCW = QW + WC + 3;
  localparam int unsigned RW  = RCW + 2 * WC;

  logic [4:0] vld_q;
  // Halves of s: signed upper part, zero-extended lower part.
  logic signed [SW-SH-1:0] s_hi [3];
  logic signed [SH:0] s_lo [3];
  // Partial products of the cross product.
  logic signed [HPW-1:0] ph_q [6];
  logic signed [LPW-1:0] pl_q [6];
  logic [NNW-1:0] nn4_q;
  logic [QQW-1:0] qq4_q;
  logic signed [QW-1:0] q4_q [3], q5_q [3];
  logic signed [WW-1:0] w_q [3];
  logic [LPP-1:0] lhs_hi_q, lhs_lo_q;
  logic nz5_q, nz6_q, nz7_q;
  // Chunks of w: two zero-extended lower parts and a signed top part.
  logic signed [WC:0] w_ch [3][3];
  logic signed [RCW-1:0] r_q [3];
  logic [LHW-1:0] lhs6_q;
  logic signed [RW-1:0] lhs7_q, rhs_q;
  csph_pkg::csph_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // Split s and w into multiplier-sized pieces.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_hi[k] = s_i[k][SW-1:SH];
      s_lo[k] = {1'b0, s_i[k][SH-1:0]};
      w_ch[k][0] = {1'b0, w_q[k][WC-1:0]};
      w_ch[k][1] = {1'b0, w_q[k][2*WC-1:WC]};
      w_ch[k][2] = w_q[k][WW-1:2*WC];
    end
  end

  // Stage 4: cross product partials on both halves of s, |n|^2 and |q|^2.
  always_ff @(posedge clk_i) begin
    ph_q[0] <= HPW'(s_hi[1] * n_i[2]);
    ph_q[1] <= HPW'(s_hi[2] * n_i[1]);
    ph_q[2] <= HPW'(s_hi[2] * n_i[0]);
    ph_q[3] <= HPW'(s_hi[0] * n_i[2]);
    ph_q[4] <= HPW'(s_hi[0] * n_i[1]);
    ph_q[5] <= HPW'(s_hi[1] * n_i[0]);
    pl_q[0] <= LPW'(s_lo[1] * n_i[2]);
    pl_q[1] <= LPW'(s_lo[2] * n_i[1]);
    pl_q[2] <= LPW'(s_lo[2] * n_i[0]);
    pl_q[3] <= LPW'(s_lo[0] * n_i[2]);
    pl_q[4] <= LPW'(s_lo[0] * n_i[1]);
    pl_q[5] <= LPW'(s_lo[1] * n_i[0]);
    nn4_q <= NNW'(n_i[0] * n_i[0]) + NNW'(n_i[1] * n_i[1]) + NNW'(n_i[2] * n_i[2]);
    qq4_q <= QQW'(q_i[0] * q_i[0]) + QQW'(q_i[1] * q_i[1]) + QQW'(q_i[2] * q_i[2]);
    q4_q <= q_i;
  end

  // Stage 5: combine into w, halves of |n|^2 |q|^2, flag collinear corners.
  always_ff @(posedge clk_i) begin
    w_q[0] <= ((WW'(ph_q[0]) - WW'(ph_q[1])) <<< SH) + WW'(pl_q[0]) - WW'(pl_q[1]);
    w_q[1] <= ((WW'(ph_q[2]) - WW'(ph_q[3])) <<< SH) + WW'(pl_q[2]) - WW'(pl_q[3]);
    w_q[2] <= ((WW'(ph_q[4]) - WW'(ph_q[5])) <<< SH) + WW'(pl_q[4]) - WW'(pl_q[5]);
    lhs_hi_q <= LPP'(nn4_q[NNW-1:NNH] * qq4_q);
    lhs_lo_q <= LPP'(nn4_q[NNH-1:0] * qq4_q);
    nz5_q <= (nn4_q != '0);
    q5_q <= q4_q;
  end

  // Stage 6: q . w per chunk, assemble |n|^2 |q|^2.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      r_q[c] <= RCW'(q5_q[0] * w_ch[0][c]) + RCW'(q5_q[1] * w_ch[1][c])
              + RCW'(q5_q[2] * w_ch[2][c]);
    end
    lhs6_q <= (LHW'(lhs_hi_q) << NNH) + LHW'(lhs_lo_q);
    nz6_q <= nz5_q;
  end

  // Stage 7: assemble q . w.
  always_ff @(posedge clk_i) begin
    rhs_q <= (RW'(r_q[2]) <<< (2 * WC)) + (RW'(r_q[1]) <<< WC) + RW'(r_q[0]);
    lhs7_q <= $signed(RW'(lhs6_q));
    nz7_q <= nz6_q;
  end

  // Stage 8: compare.
  always_ff @(posedge clk_i) begin
    res_q.degenerate <= !nz7_q;
    res_q.inside_res <= nz7_q && (lhs7_q < rhs_q);
  end

  assign valid_o = vld_q[4];
  assign res_o = res_q;

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(res_o.inside_res && res_o.degenerate)) else $error("both flags set");
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !$isunknown(res_o)) else $error("unknown result");
  a_deg_lhs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && !nz6_q) |-> (lhs6_q == '0)) else $error("bad lhs on collinear corners");
  a_deg_rhs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && !nz7_q) |-> (rhs_q == '0)) else $error("bad rhs on collinear corners");
endmodule

// ===== rtl/circumsphere_point_inside_test_core.sv =====
// done_o strobes once for each accepted start, after the geom and test pipeline stages.
// Throughput: one transaction per cycle; busy is never raised.
// The cross product is split into multiplier-sized halves of s.
// Reset: asynchronous active-low clears the valid pipeline only.
// The receiver cannot stall; each result shows for exactly one cycle.
module circumsphere_point_inside_test_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  csph_pkg::csph_in_t  item_i,
  output logic                done_o,
  output csph_pkg::csph_out_t res_o
);
  logic g_valid;
  logic signed [csph_pkg::CoordBits+1:0]   q_w [3];
  logic signed [2*csph_pkg::CoordBits+3:0] n_w [3];
  logic signed [4*csph_pkg::CoordBits+7:0] s_w [3];

  assign busy = 1'b0;

  csph_geom u_geom (
    .clk_i, .rst_ni, .valid_i(start && !busy), .item_i,
    .valid_o(g_valid), .q_o(q_w), .n_o(n_w), .s_o(s_w)
  );

  csph_test u_test (
    .clk_i, .rst_ni, .valid_i(g_valid), .q_i(q_w), .n_i(n_w), .s_i(s_w),
    .valid_o(done_o), .res_o
  );
endmodule
